>>> hw/rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// Deque package
// Shared sizes, command codes and the request bundle that runs from the
// controller to the entry store.
// ----------------------------------------------------------------------------
package deq_pkg;

	// Store geometry and derived widths.
	localparam int DEPTH       = 64;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int COUNT_W     = $clog2(DEPTH + 1);
	localparam int WORD_W      = 32;
	localparam int CMD_W       = 3;

	// Stream beat widths, rounded up to whole bytes.
	localparam int IN_FIELDS_W  = CMD_W + WORD_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 2 * WORD_W + COUNT_W + 2;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Value reported for front and rear when nothing is stored.
	localparam logic [WORD_W-1:0] INT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

	// Command codes.
	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_REAR  = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_POP_REAR   = 3'd2,
		CMD_POP_FRONT  = 3'd3,
		CMD_CLEAR      = 3'd4
	} cmd_t;

	// Write and read requests towards the entry store.
	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [WORD_W-1:0] wr_data;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr_front;
		logic [ADDR_W-1:0] rd_addr_rear;
	} store_req_t;

endpackage

>>> hw/rtl/deq_store.sv
// ----------------------------------------------------------------------------
// Deque entry store
// Synchronous memory with one write port and two read ports; read data is
// registered and holds until the next read enable.
// ----------------------------------------------------------------------------
module deq_store (
	input  logic                            clk,
	input  deq_pkg::store_req_t             req,
	output logic [deq_pkg::WORD_W-1:0]      rd_front,
	output logic [deq_pkg::WORD_W-1:0]      rd_rear
);
	import deq_pkg::*;

	logic [WORD_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	// Two registered read ports sharing one enable.
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_front <= mem[req.rd_addr_front];
			rd_rear  <= mem[req.rd_addr_rear];
		end
	end

endmodule

>>> hw/rtl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// Deque controller
// Holds the head pointer and occupancy, decodes each command, issues the
// store write and the read of the new front and rear, and forms the result.
// ----------------------------------------------------------------------------
module deq_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [deq_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [deq_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output deq_pkg::store_req_t                 req,
	input  logic [deq_pkg::WORD_W-1:0]          rd_front,
	input  logic [deq_pkg::WORD_W-1:0]          rd_rear
);
	import deq_pkg::*;

	localparam int SUM_W = $clog2(2 * DEPTH);
	localparam int PAD_W = OUT_TDATA_W - OUT_FIELDS_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_OUT
	} state_t;

	state_t             state_q;
	logic [ADDR_W-1:0]  head_q;
	logic [COUNT_W-1:0] occ_q;
	logic               dropped_q;

	cmd_t               cmd;
	logic [WORD_W-1:0]  word;
	logic               accept;
	logic               full;
	logic               empty;
	logic [ADDR_W-1:0]  tail_addr;
	logic [ADDR_W-1:0]  head_dec;
	logic [ADDR_W-1:0]  head_inc;
	logic [ADDR_W-1:0]  rear_addr;
	logic [ADDR_W-1:0]  head_d;
	logic [COUNT_W-1:0] occ_d;
	logic               drop_d;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [WORD_W-1:0]  front_val;
	logic [WORD_W-1:0]  rear_val;

	// Folds a sum below twice the depth back into the index range.
	function automatic logic [ADDR_W-1:0] wrap_index(input logic [SUM_W-1:0] i);
		logic [SUM_W-1:0] r;
		begin
			r = (i >= SUM_W'(DEPTH)) ? (i - SUM_W'(DEPTH)) : i;
			return r[ADDR_W-1:0];
		end
	endfunction

	// Field extraction and pointer arithmetic.
	assign cmd       = cmd_t'(s_tdata[CMD_W-1:0]);
	assign word      = s_tdata[CMD_W +: WORD_W];
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = (state_q == ST_OUT);
	assign accept    = s_tvalid && s_tready;
	assign full      = (occ_q == COUNT_W'(DEPTH));
	assign empty     = (occ_q == '0);
	assign tail_addr = wrap_index(SUM_W'(head_q) + SUM_W'(occ_q));
	assign head_dec  = (head_q == '0) ? ADDR_W'(DEPTH - 1) : (head_q - 1'b1);
	assign head_inc  = wrap_index(SUM_W'(head_q) + SUM_W'(1));
	assign rear_addr = wrap_index(SUM_W'(head_q) + SUM_W'(occ_q) - SUM_W'(1));

	// Command decode: next pointer, next count, drop flag and the store write.
	always_comb begin
		head_d  = head_q;
		occ_d   = occ_q;
		drop_d  = 1'b0;
		wr_en   = 1'b0;
		wr_addr = tail_addr;
		unique case (cmd)
			CMD_PUSH_REAR: begin
				if (full) begin
					drop_d = 1'b1;
				end else begin
					wr_en = 1'b1;
					occ_d = occ_q + 1'b1;
				end
			end
			CMD_PUSH_FRONT: begin
				wr_addr = head_dec;
				if (full) begin
					drop_d = 1'b1;
				end else begin
					wr_en  = 1'b1;
					head_d = head_dec;
					occ_d  = occ_q + 1'b1;
				end
			end
			CMD_POP_REAR: begin
				if (!empty) begin
					occ_d = occ_q - 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				if (!empty) begin
					head_d = head_inc;
					occ_d  = occ_q - 1'b1;
				end
			end
			CMD_CLEAR: begin
				head_d = '0;
				occ_d  = '0;
			end
			default: begin
			end
		endcase
	end

	// Store requests: write on the accepted beat, read in the cycle after it so the
	// read always sees the completed write.
	always_comb begin
		req.wr_en         = accept && wr_en;
		req.wr_addr       = wr_addr;
		req.wr_data       = word;
		req.rd_en         = (state_q == ST_READ);
		req.rd_addr_front = head_q;
		req.rd_addr_rear  = rear_addr;
	end

	// Sequencer and pointer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			head_q    <= '0;
			occ_q     <= '0;
			dropped_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						head_q    <= head_d;
						occ_q     <= occ_d;
						dropped_q <= drop_d;
						state_q   <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (m_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result beat; an empty deque reports the most negative value.
	assign front_val = empty ? INT_MIN : rd_front;
	assign rear_val  = empty ? INT_MIN : rd_rear;
	assign m_tdata   = {{PAD_W{1'b0}}, dropped_q, empty, occ_q, rear_val, front_val};

endmodule

>>> hw/rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded circular deque of signed 32-bit words with push and pop at both
// ends and clear; every command returns front, rear, count and flags.
//
//   Port group  Dir  Beat contents (lowest bits first)
//   s_*         in   command[2:0], data_word[34:3], zero pad to 40 bits
//   m_*         out  front_value[31:0], rear_value[63:32], entry_count[70:64],
//                    is_empty[71], push_dropped[72], zero pad to 80 bits
//
// Each command runs through accept and store write, then a registered read
// of the new front and rear entries, then the result beat, which may stall.
// The next command can be accepted the cycle after the result beat is taken;
// a new command is not taken while the last one is still in flight.
// Reset empties the deque at once; no clearing pass runs over the store.
// ----------------------------------------------------------------------------
module double_ended_queue (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [deq_pkg::IN_TDATA_W-1:0]    s_tdata,  // command, data_word
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [deq_pkg::OUT_TDATA_W-1:0]   m_tdata   // front_value, rear_value,
	                                                     // entry_count, is_empty,
	                                                     // push_dropped
);
	import deq_pkg::*;

	store_req_t        req;
	logic [WORD_W-1:0] rd_front;
	logic [WORD_W-1:0] rd_rear;

	// Pointer control and result forming.
	deq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.req      (req),
		.rd_front (rd_front),
		.rd_rear  (rd_rear)
	);

	// Entry memory.
	deq_store u_store (
		.clk      (clk),
		.req      (req),
		.rd_front (rd_front),
		.rd_rear  (rd_rear)
	);

	// The count reported never exceeds the store depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2*WORD_W +: COUNT_W] <= COUNT_W'(DEPTH)))
		else $error("deque count beyond depth");

	// The empty flag agrees with the count.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2*WORD_W + COUNT_W] == (m_tdata[2*WORD_W +: COUNT_W] == '0)))
		else $error("deque empty flag disagrees with count");

	// Only one command is in flight: no input beat while a result is offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("deque input open while result pending");

	// A taken result reopens the input on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready) |=> s_tready)
		else $error("deque input not reopened after result");

	// An accepted command blocks further input until its result is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (!s_tready && !m_tvalid))
		else $error("deque command sequencing broken");

endmodule
